FILE: design/tdpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test: shared package
// Widths, microcode word layout and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int WIDTH      = 32;
	localparam int IN_TDATA_W = ((WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS   = WIDTH + 2;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int CNT_W      = $clog2(WIDTH + 1);
	localparam int UPC_W      = 5;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_X_LT2,
		C_X_EVEN,
		C_X_IS2,
		C_SQ_GT,
		C_DIV_BUSY,
		C_REM_ZERO,
		C_PHASE0,
		C_VERDICT,
		C_C_MAX,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic ld_in;
		logic ld_d3;
		logic mul;
		logic div_start;
		logic d_inc;
		logic v_clr;
		logic v_set;
		logic save_p;
		logic inc_c;
		logic set_found;
		logic set_ovf;
		logic out_load;
	} ops_t;

	typedef struct packed {
		cond_t cond;
		upc_t  jt;
		upc_t  jf;
		ops_t  ops;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic x_lt2;
		logic x_even;
		logic x_is2;
		logic sq_gt;
		logic div_busy;
		logic rem_zero;
		logic phase0;
		logic verdict;
		logic c_max;
		logic out_free;
	} status_t;

	localparam upc_t S_IDLE   = 5'd0;
	localparam upc_t S_TEST   = 5'd1;
	localparam upc_t S_EVEN   = 5'd2;
	localparam upc_t S_TWO    = 5'd3;
	localparam upc_t S_LOOP   = 5'd4;
	localparam upc_t S_BOUND  = 5'd5;
	localparam upc_t S_WAIT   = 5'd6;
	localparam upc_t S_REM    = 5'd7;
	localparam upc_t S_NP     = 5'd8;
	localparam upc_t S_PR     = 5'd9;
	localparam upc_t S_RET    = 5'd10;
	localparam upc_t S_SAVE   = 5'd11;
	localparam upc_t S_CHECK  = 5'd12;
	localparam upc_t S_SEARCH = 5'd13;
	localparam upc_t S_FOUND  = 5'd14;
	localparam upc_t S_OVF    = 5'd15;
	localparam upc_t S_OUT    = 5'd16;

	function automatic uword_t ucode(upc_t a);
		uword_t w;
		w = '0;
		w.cond = C_ALWAYS;
		unique case (a)
			S_IDLE: begin
				w.cond = C_IN_VALID; w.jt = S_TEST; w.jf = S_IDLE; w.ops.ld_in = 1'b1;
			end
			S_TEST: begin
				w.cond = C_X_LT2; w.jt = S_NP; w.jf = S_EVEN;
			end
			S_EVEN: begin
				w.cond = C_X_EVEN; w.jt = S_TWO; w.jf = S_LOOP; w.ops.ld_d3 = 1'b1;
			end
			S_TWO: begin
				w.cond = C_X_IS2; w.jt = S_PR; w.jf = S_NP;
			end
			S_LOOP: begin
				w.jt = S_BOUND; w.ops.mul = 1'b1;
			end
			S_BOUND: begin
				w.cond = C_SQ_GT; w.jt = S_PR; w.jf = S_WAIT; w.ops.div_start = 1'b1;
			end
			S_WAIT: begin
				w.cond = C_DIV_BUSY; w.jt = S_WAIT; w.jf = S_REM;
			end
			S_REM: begin
				w.cond = C_REM_ZERO; w.jt = S_NP; w.jf = S_LOOP; w.ops.d_inc = 1'b1;
			end
			S_NP: begin
				w.jt = S_RET; w.ops.v_clr = 1'b1;
			end
			S_PR: begin
				w.jt = S_RET; w.ops.v_set = 1'b1;
			end
			S_RET: begin
				w.cond = C_PHASE0; w.jt = S_SAVE; w.jf = S_CHECK;
			end
			S_SAVE: begin
				w.jt = S_SEARCH; w.ops.save_p = 1'b1;
			end
			S_CHECK: begin
				w.cond = C_VERDICT; w.jt = S_FOUND; w.jf = S_SEARCH;
			end
			S_SEARCH: begin
				w.cond = C_C_MAX; w.jt = S_OVF; w.jf = S_TEST; w.ops.inc_c = 1'b1;
			end
			S_FOUND: begin
				w.jt = S_OUT; w.ops.set_found = 1'b1;
			end
			S_OVF: begin
				w.jt = S_OUT; w.ops.set_ovf = 1'b1;
			end
			S_OUT: begin
				w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_OUT; w.ops.out_load = 1'b1;
			end
			default: begin
				w.jt = S_IDLE; w.jf = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: design/trial_division_prime_test_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test unit
// Tests one number for primality and finds the smallest greater prime.
// ----------------------------------------------------------------------------
// Each request on the s_ group carries one 32-bit number. The unit answers with
// one request on the m_ group: a prime flag, the next prime above the number,
// and an overflow flag (next prime then reads 0) when no greater prime fits.
// One number is handled at a time; s_tready is high only while the sequencer
// waits in its idle step. A small microcode program drives the datapath: it
// tests the number, then walks candidates upward and tests each in turn.
// Each odd trial divisor passes through the loop step (square of the divisor),
// the bound step, the wait step while the bit-serial remainder unit runs, and
// the remainder step. The time to an answer grows with the total count of odd
// divisors tried over the number and all candidates.
// The result sits in an output register and is held there while the receiver
// stalls. The next number is still taken; the sequencer waits in its output
// step only when the following result is ready before the held one has left.
// Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [tdpt_pkg::IN_TDATA_W-1:0]    s_tdata,  // number
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [tdpt_pkg::OUT_TDATA_W-1:0]        m_tdata   // number_is_prime, next_prime, overflow
);
	import tdpt_pkg::*;

	ops_t               ops;
	status_t            st;
	logic [WIDTH-1:0]   x_q;
	logic [WIDTH-1:0]   c_q;
	logic [WIDTH-1:0]   d_q;
	logic [2*WIDTH-1:0] sq_q;
	logic               phase_q;
	logic               verdict_q;
	logic               res_p_q;
	logic [WIDTH-1:0]   res_n_q;
	logic               res_o_q;
	logic               m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic               div_busy;
	logic               rem_zero;
	logic               out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = ops.ld_in;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		st.in_valid = s_tvalid;
		st.x_lt2    = x_q[WIDTH-1:1] == '0;
		st.x_even   = !x_q[0];
		st.x_is2    = x_q == WIDTH'(2);
		st.sq_gt    = sq_q > {{WIDTH{1'b0}}, x_q};
		st.div_busy = div_busy;
		st.rem_zero = rem_zero;
		st.phase0   = !phase_q;
		st.verdict  = verdict_q;
		st.c_max    = c_q == '1;
		st.out_free = out_free;
	end

	tdpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ops    (ops)
	);

	tdpt_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ops.div_start && !st.sq_gt),
		.dividend (x_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ops.out_load && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ops.ld_in && s_tvalid) begin
			x_q     <= s_tdata[WIDTH-1:0];
			c_q     <= s_tdata[WIDTH-1:0];
			phase_q <= 1'b0;
		end
		if (ops.inc_c) begin
			x_q     <= c_q + 1'b1;
			c_q     <= c_q + 1'b1;
			phase_q <= 1'b1;
		end
		if (ops.ld_d3) begin
			d_q <= WIDTH'(3);
		end
		if (ops.d_inc) begin
			d_q <= d_q + WIDTH'(2);
		end
		if (ops.mul) begin
			sq_q <= (2*WIDTH)'(d_q) * (2*WIDTH)'(d_q);
		end
		if (ops.v_clr) begin
			verdict_q <= 1'b0;
		end
		if (ops.v_set) begin
			verdict_q <= 1'b1;
		end
		if (ops.save_p) begin
			res_p_q <= verdict_q;
		end
		if (ops.set_found) begin
			res_n_q <= c_q;
			res_o_q <= 1'b0;
		end
		if (ops.set_ovf) begin
			res_n_q <= '0;
			res_o_q <= 1'b1;
		end
		if (ops.out_load && out_free) begin
			m_tdata_q <= OUT_TDATA_W'({res_o_q, res_n_q, res_p_q});
		end
	end

`ifndef ASSERT_OFF
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("Remainder unit busy while the unit is idle.");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[WIDTH+1] |-> m_tdata[WIDTH:1] == '0)
		else $error("Overflow result carries a nonzero next prime.");

	a_next_odd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[WIDTH+1] |-> m_tdata[1] || m_tdata[WIDTH:1] == WIDTH'(2))
		else $error("Next prime is even and not two.");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("Result appeared one cycle after a request was taken.");
`endif

endmodule
`default_nettype wire

FILE: design/tdpt_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test: remainder unit
// Restoring division, one quotient bit per cycle; keeps only the remainder.
// ----------------------------------------------------------------------------
module tdpt_rem (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [tdpt_pkg::WIDTH-1:0] dividend,
	input  wire logic [tdpt_pkg::WIDTH-1:0] divisor,
	output logic                          busy,
	output logic                          rem_zero
);
	import tdpt_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH-1:0] dvs_q;
	logic [WIDTH:0]   trial;
	logic             fits;

	assign trial    = {rem_q, dvd_q[WIDTH-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign busy     = cnt_q != '0;
	assign rem_zero = rem_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(WIDTH);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			if (fits) begin
				rem_q <= WIDTH'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[WIDTH-1:0];
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/tdpt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test: microcode sequencer
// Step counter, program table lookup and conditional jump selection.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tdpt_pkg::status_t st,
	output tdpt_pkg::ops_t         ops
);
	import tdpt_pkg::*;

	upc_t   upc_q;
	upc_t   upc_d;
	uword_t w;
	logic   taken;

	assign w = ucode(upc_q);

	always_comb begin
		unique case (w.cond)
			C_ALWAYS:   taken = 1'b1;
			C_IN_VALID: taken = st.in_valid;
			C_X_LT2:    taken = st.x_lt2;
			C_X_EVEN:   taken = st.x_even;
			C_X_IS2:    taken = st.x_is2;
			C_SQ_GT:    taken = st.sq_gt;
			C_DIV_BUSY: taken = st.div_busy;
			C_REM_ZERO: taken = st.rem_zero;
			C_PHASE0:   taken = st.phase0;
			C_VERDICT:  taken = st.verdict;
			C_C_MAX:    taken = st.c_max;
			C_OUT_FREE: taken = st.out_free;
			default:    taken = 1'b1;
		endcase
		upc_d = taken ? w.jt : w.jf;
	end

	always_comb begin
		ops = w.ops;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule
`default_nettype wire
